/* rtl/business_days_between_dates_top_macros.svh */
// assertion helpers for the business day counter
// each macro has a checking form and an empty form for synthesis
`ifndef BUSINESS_DAYS_BETWEEN_DATES_TOP_MACROS_SVH
`define BUSINESS_DAYS_BETWEEN_DATES_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BDBD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BDBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDBD_ASSERT(lbl, clk, rstn, prop, msg)
`define BDBD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* rtl/bdbd_pkg.sv */
// ----------------------------------------------------------------------------
// bdbd_pkg
// Shared widths, constants and calendar tables for the business day counter.
// ----------------------------------------------------------------------------
`default_nettype none

package bdbd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DN_W    = 22;
    localparam int CNT_W   = 22;
    localparam int MASK_W  = 7;
    localparam int WD_W    = 3;
    localparam int Q100_W  = 8;
    localparam int Q7_W    = 20;

    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
    localparam logic [MASK_W-1:0] MASK_RESET = 7'h60;

    // x / 100 = (x * 5243) >> 19 for 14-bit x
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    // x / 7 = (x * ceil(2^25 / 7)) >> 25 for 22-bit x
    localparam logic [22:0] DIV7_MUL   = 23'd4793491;
    localparam int          DIV7_SHIFT = 25;

    // day number plus this, modulo 7, gives the weekday with sunday = 0
    localparam logic [1:0] DN_WEEKDAY_OFFSET = 2'd3;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic bad;
        logic start_lt;
    } flags_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // days from march 1 to the first of the month, year starting in march
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [8:0] off;
        case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

/* rtl/bdbd_date_unit.sv */
// ----------------------------------------------------------------------------
// bdbd_date_unit
// Two-stage date checker and day number builder for one calendar date.
// ----------------------------------------------------------------------------
`default_nettype none

module bdbd_date_unit
    import bdbd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [YEAR_W-1:0]  year,
    input  wire logic [MONTH_W-1:0] month,
    input  wire logic [DAY_W-1:0]   day,
    output logic      [DN_W-1:0]    day_num,
    output logic                    date_ok
);

    // stage one: shifted year and divisions by 100
    logic [YEAR_W-1:0]  yy;
    logic [26:0]        prod_y;
    logic [26:0]        prod_yy;
    logic               range_ok;

    logic [YEAR_W-1:0]  y_reg;
    logic [MONTH_W-1:0] m_reg;
    logic [DAY_W-1:0]   d_reg;
    logic [YEAR_W-1:0]  yy_reg;
    logic [Q100_W-1:0]  qy_reg;
    logic [Q100_W-1:0]  qyy_reg;
    logic               range_ok_reg;

    always_comb begin
        yy       = (month <= MONTH_FEB) ? year - YEAR_W'(1) : year;
        prod_y   = 27'(year) * 27'(DIV100_MUL);
        prod_yy  = 27'(yy) * 27'(DIV100_MUL);
        range_ok = (year != '0) && (year <= YEAR_MAX) && (month != '0)
                   && (month <= MONTH_DEC) && (day != '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg        <= year;
            m_reg        <= month;
            d_reg        <= day;
            yy_reg       <= yy;
            qy_reg       <= prod_y[DIV100_SHIFT +: Q100_W];
            qyy_reg      <= prod_yy[DIV100_SHIFT +: Q100_W];
            range_ok_reg <= range_ok;
        end
    end

    // stage two: leap rule, month length, day number
    logic [14:0]     hundred_mul;
    logic            div100;
    logic            leap;
    logic            ok_next;
    logic [23:0]     dn_next;
    logic [DN_W-1:0] dn_reg;
    logic            ok_reg;

    always_comb begin
        hundred_mul = 15'(qy_reg) * 15'd100;
        div100      = ({1'b0, y_reg} == hundred_mul);
        leap        = (y_reg[1:0] == 2'b00) && (!div100 || (qy_reg[1:0] == 2'b00));
        ok_next     = range_ok_reg && (d_reg <= month_len(m_reg, leap));
        dn_next     = 24'(yy_reg) * 24'd365 + 24'(yy_reg >> 2) - 24'(qyy_reg)
                      + 24'(qyy_reg >> 2) + 24'(month_offset(m_reg))
                      + 24'(d_reg) - 24'd1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dn_reg <= dn_next[DN_W-1:0];
            ok_reg <= ok_next;
        end
    end

    assign day_num = dn_reg;
    assign date_ok = ok_reg;

endmodule

`default_nettype wire

/* rtl/bdbd_div7.sv */
// ----------------------------------------------------------------------------
// bdbd_div7
// Registered divide by seven by reciprocal multiply, remainder after the stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bdbd_div7
    import bdbd_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [DN_W-1:0] dividend,
    output logic      [Q7_W-1:0] quotient,
    output logic      [WD_W-1:0] remainder
);

    logic [44:0]     prod;
    logic [DN_W-1:0] x_reg;
    logic [Q7_W-1:0] q_reg;
    logic [WD_W-1:0] q7_low;

    assign prod = 45'(dividend) * 45'(DIV7_MUL);

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= dividend;
            q_reg <= prod[DIV7_SHIFT +: Q7_W];
        end
    end

    // true remainder is below 7, so the low bits of the difference suffice
    always_comb begin
        q7_low    = WD_W'({q_reg[WD_W-1:0], 3'b000} - {3'b000, q_reg[WD_W-1:0]});
        remainder = x_reg[WD_W-1:0] - q7_low;
    end

    assign quotient = q_reg;

endmodule

`default_nettype wire

/* rtl/bdbd_count.sv */
// ----------------------------------------------------------------------------
// bdbd_count
// Business day total from whole weeks plus the leftover partial week.
// ----------------------------------------------------------------------------
`default_nettype none

module bdbd_count
    import bdbd_pkg::*;
(
    input  wire logic [MASK_W-1:0] weekend_mask,
    input  wire logic [Q7_W-1:0]   weeks,
    input  wire logic [WD_W-1:0]   rem_days,
    input  wire logic [WD_W-1:0]   start_wd,
    input  wire flags_t            flags,
    output logic      [CNT_W-1:0]  count
);

    logic [WD_W-1:0]   per_week;
    logic [MASK_W-1:0] work_rot;
    logic [WD_W-1:0]   partial;
    logic [3:0]        idx;
    logic [22:0]       full;

    always_comb begin
        per_week = '0;
        partial  = '0;
        work_rot = '0;
        idx      = '0;
        for (int i = 0; i < MASK_W; i++) begin
            per_week = per_week + WD_W'(!weekend_mask[i]);
            // work day bits rotated to start at the first date's weekday
            idx = 4'(start_wd) + 4'(i);
            if (idx >= 4'd7) begin
                idx = idx - 4'd7;
            end
            work_rot[i] = !weekend_mask[idx[WD_W-1:0]];
        end
        for (int i = 0; i < MASK_W; i++) begin
            if (WD_W'(i) < rem_days) begin
                partial = partial + WD_W'(work_rot[i]);
            end
        end
        full = 23'(weeks) * 23'(per_week);
        if (flags.bad || !flags.start_lt) begin
            count = '0;
        end else begin
            count = full[CNT_W-1:0] + CNT_W'(partial);
        end
    end

endmodule

`default_nettype wire

/* rtl/business_days_between_dates_top.sv */
// ----------------------------------------------------------------------------
// business_days_between_dates_top
// Counts non-weekend days from a start date up to an excluded end date.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one word holding a start date and an end date. m_ channel
//   returns one word per request: business_days and bad_date. a date with an
//   out-of-range year, month or day raises bad_date and gives a zero count.
//   a start date on or after the end date gives zero with bad_date low.
//   the cfg channel writes the 7-bit weekend mask (bit 0 sunday), always
//   ready; write it only while no request is in flight.
// timing:
//   five register stages, the first loaded by the accepting edge: two per date
//   for day numbers, one for the difference, one for the divide by seven
//   multiplier, and the output register behind the week count, which raises
//   m_valid. one word per cycle sustained while m_ready stays high.
// reset:
//   aresetn low empties every stage and loads the mask with friday/saturday.
// stall:
//   when a result waits with m_ready low the whole pipeline holds and s_ready
//   drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "business_days_between_dates_top_macros.svh"

module business_days_between_dates_top
    import bdbd_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [MASK_W-1:0]  cfg_weekend_mask,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [YEAR_W-1:0]  s_from_year,
    input  wire logic [MONTH_W-1:0] s_from_month,
    input  wire logic [DAY_W-1:0]   s_from_day,
    input  wire logic [YEAR_W-1:0]  s_to_year,
    input  wire logic [MONTH_W-1:0] s_to_month,
    input  wire logic [DAY_W-1:0]   s_to_day,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CNT_W-1:0]        m_business_days,
    output logic                    m_bad_date
);

    logic              adv;
    logic [MASK_W-1:0] weekend_mask_reg;
    logic [4:1]        stg_valid_reg;
    logic              m_valid_reg;
    logic [CNT_W-1:0]  m_business_days_reg;
    logic              m_bad_date_reg;

    assign adv       = !m_valid_reg || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weekend_mask_reg <= MASK_RESET;
        end else if (cfg_valid) begin
            weekend_mask_reg <= cfg_weekend_mask;
        end
    end

    // stages one and two
    logic [DN_W-1:0] dn_from;
    logic [DN_W-1:0] dn_to;
    logic            ok_from;
    logic            ok_to;

    bdbd_date_unit u_from (
        .aclk    (aclk),
        .en      (adv),
        .year    (s_from_year),
        .month   (s_from_month),
        .day     (s_from_day),
        .day_num (dn_from),
        .date_ok (ok_from)
    );

    bdbd_date_unit u_to (
        .aclk    (aclk),
        .en      (adv),
        .year    (s_to_year),
        .month   (s_to_month),
        .day     (s_to_day),
        .day_num (dn_to),
        .date_ok (ok_to)
    );

    // stage three: span and weekday base
    logic [DN_W-1:0] span_reg;
    logic [DN_W-1:0] wd_base_reg;
    flags_t          flags3_reg;
    flags_t          flags4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            span_reg            <= dn_to - dn_from;
            wd_base_reg         <= dn_from + DN_W'(DN_WEEKDAY_OFFSET);
            flags3_reg.bad      <= !(ok_from && ok_to);
            flags3_reg.start_lt <= dn_from < dn_to;
            flags4_reg          <= flags3_reg;
        end
    end

    // stage four: divide span and base by seven
    logic [Q7_W-1:0] weeks;
    logic [WD_W-1:0] rem_days;
    logic [Q7_W-1:0] wd_quot;
    logic [WD_W-1:0] start_wd;

    bdbd_div7 u_div_span (
        .aclk      (aclk),
        .en        (adv),
        .dividend  (span_reg),
        .quotient  (weeks),
        .remainder (rem_days)
    );

    bdbd_div7 u_div_wd (
        .aclk      (aclk),
        .en        (adv),
        .dividend  (wd_base_reg),
        .quotient  (wd_quot),
        .remainder (start_wd)
    );

    // stage five: week count into the output register
    logic [CNT_W-1:0] count;

    bdbd_count u_count (
        .weekend_mask (weekend_mask_reg),
        .weeks        (weeks),
        .rem_days     (rem_days),
        .start_wd     (start_wd),
        .flags        (flags4_reg),
        .count        (count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else if (adv) begin
            stg_valid_reg <= {stg_valid_reg[3:1], s_valid};
            m_valid_reg   <= stg_valid_reg[4];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_business_days_reg <= count;
            m_bad_date_reg      <= flags4_reg.bad;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_business_days = m_business_days_reg;
    assign m_bad_date      = m_bad_date_reg;

    `BDBD_ASSERT(a_bad_gives_zero, aclk, aresetn, m_valid_reg && m_bad_date_reg |-> m_business_days_reg == '0, "bad date with nonzero count")
    `BDBD_ASSERT(a_all_weekend_zero, aclk, aresetn, m_valid_reg && (weekend_mask_reg == 7'h7f) |-> m_business_days_reg == '0, "count nonzero with every day masked")
    `BDBD_ASSERT(a_stall_holds_stages, aclk, aresetn, !adv |=> $stable(stg_valid_reg) && m_valid_reg, "pipeline moved during stall")
    `BDBD_ASSERT(a_last_stage_lands, aclk, aresetn, stg_valid_reg[4] && adv |=> m_valid_reg, "word lost at output register")
    `BDBD_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid_reg && (stg_valid_reg == '0), "pipeline not empty after reset")

endmodule

`default_nettype wire

/* verif/business_days_between_dates_top_tb.sv */
// ----------------------------------------------------------------------------
// business_days_between_dates_top_tb
// Self-checking bench for the business day counter. Requests are driven on
// the s_ channel and results are taken from the m_ channel, both with random
// idle cycles. A scoreboard predicts each count from the calendar arithmetic
// and the current weekend mask. The run starts with hand-picked dates and
// then sends random date pairs under several weekend masks.
// ----------------------------------------------------------------------------
module business_days_between_dates_top_tb
    import bdbd_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 330;
    localparam int LONG_HOLD    = 400;

    typedef struct {
        logic [CNT_W-1:0] days;
        logic             bad;
    } count_word_t;

    class day_count_board;
        count_word_t       expected_q[$];
        logic [MASK_W-1:0] weekend_mask;
        int                errors;

        function new();
            weekend_mask = MASK_RESET;
            errors = 0;
        endfunction

        // month must be 1..12 here
        function int month_days(int y, int m);
            int len;
            case (m)
                2: begin
                    len = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
                end
                4, 6, 9, 11: begin
                    len = 30;
                end
                default: begin
                    len = 31;
                end
            endcase
            return len;
        endfunction

        function bit date_valid(int y, int m, int d);
            if (y < 1 || y > int'(YEAR_MAX) || m < 1 || m > 12 || d < 1)
                return 1'b0;
            return d <= month_days(y, m);
        endfunction

        // serial day count with the year starting in march, so leap day falls last
        function int day_serial(int y, int m, int d);
            int yy;
            int mp;
            yy = (m < 3) ? y - 1 : y;
            mp = (m < 3) ? m + 9 : m - 3;
            return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d - 1;
        endfunction

        function void note_request(int fy, int fm, int fd, int ty, int tm, int td);
            count_word_t w;
            int first_dn;
            int end_dn;
            int span;
            int wd;
            int per_week;
            w.days = '0;
            w.bad  = 1'b0;
            if (!date_valid(fy, fm, fd) || !date_valid(ty, tm, td)) begin
                w.bad = 1'b1;
            end else begin
                first_dn = day_serial(fy, fm, fd);
                end_dn   = day_serial(ty, tm, td);
                if (first_dn < end_dn) begin
                    span = end_dn - first_dn;
                    // serial day 0 falls on a wednesday
                    wd = (first_dn + 3) % 7;
                    per_week = 7 - $countones(weekend_mask);
                    w.days = CNT_W'((span / 7) * per_week);
                    for (int i = 0; i < span % 7; i++) begin
                        if (!weekend_mask[(wd + i) % 7])
                            w.days = w.days + 1'b1;
                    end
                end
            end
            expected_q.push_back(w);
        endfunction

        function void check_result(logic [CNT_W-1:0] days, logic bad);
            count_word_t w;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing pending: days=%0d bad=%0b",
                         $time, days, bad);
                return;
            end
            w = expected_q.pop_front();
            if (days !== w.days) begin
                errors++;
                $display("%0t: business_days expected %0d got %0d", $time, w.days, days);
            end
            if (bad !== w.bad) begin
                errors++;
                $display("%0t: bad_date expected %0b got %0b", $time, w.bad, bad);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [MASK_W-1:0]   cfg_weekend_mask;
    logic                s_valid;
    logic                s_ready;
    logic [YEAR_W-1:0]   s_from_year;
    logic [MONTH_W-1:0]  s_from_month;
    logic [DAY_W-1:0]    s_from_day;
    logic [YEAR_W-1:0]   s_to_year;
    logic [MONTH_W-1:0]  s_to_month;
    logic [DAY_W-1:0]    s_to_day;
    logic                m_valid;
    logic                m_ready;
    logic [CNT_W-1:0]    m_business_days;
    logic                m_bad_date;

    day_count_board board;
    int send_idle_pct;
    int recv_idle_pct;
    bit long_hold_armed;
    int hold_left;
    int cycle_count;

    business_days_between_dates_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_weekend_mask (cfg_weekend_mask),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_from_year      (s_from_year),
        .s_from_month     (s_from_month),
        .s_from_day       (s_from_day),
        .s_to_year        (s_to_year),
        .s_to_month       (s_to_month),
        .s_to_day         (s_to_day),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_business_days  (m_business_days),
        .m_bad_date       (m_bad_date)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // result side: take words, then decide ready for the next edge
    initial begin
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                board.check_result(m_business_days, m_bad_date);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (long_hold_armed) begin
                // long back-pressure so the pipeline fills and s_ready drops
                long_hold_armed = 1'b0;
                hold_left = LONG_HOLD;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(input int fy, input int fm, input int fd,
                                input int ty, input int tm, input int td);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_from_year  <= YEAR_W'(fy);
        s_from_month <= MONTH_W'(fm);
        s_from_day   <= DAY_W'(fd);
        s_to_year    <= YEAR_W'(ty);
        s_to_month   <= MONTH_W'(tm);
        s_to_day     <= DAY_W'(td);
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_request(fy, fm, fd, ty, tm, td);
    endtask

    task automatic write_weekend_mask(input logic [MASK_W-1:0] value);
        cfg_valid        <= 1'b1;
        cfg_weekend_mask <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        board.weekend_mask = value;
    endtask

    function automatic void pick_date(output int y, output int m, output int d);
        if ($urandom_range(9) == 0)
            y = $urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(9997, 9999);
        else
            y = $urandom_range(1, int'(YEAR_MAX));
        m = $urandom_range(1, 12);
        d = $urandom_range(1, board.month_days(y, m));
    endfunction

    // break a valid date in one field
    function automatic void spoil_date(inout int y, inout int m, inout int d);
        int len;
        len = board.month_days(y, m);
        case ($urandom_range(3))
            0: begin
                d = (len < 31) ? len + 1 : 0;
            end
            1: begin
                d = 0;
            end
            2: begin
                m = $urandom_range(1) ? 0 : $urandom_range(13, 15);
            end
            default: begin
                y = $urandom_range(1) ? 0 : $urandom_range(int'(YEAR_MAX) + 1, 2**YEAR_W - 1);
            end
        endcase
    endfunction

    task automatic send_random_request();
        int fy, fm, fd, ty, tm, td;
        int pick;
        pick_date(fy, fm, fd);
        pick = $urandom_range(99);
        if (pick < 30) begin
            // same month: short spans in either order
            ty = fy;
            tm = fm;
            td = $urandom_range(1, board.month_days(fy, fm));
        end else if (pick < 55) begin
            ty = (fy < int'(YEAR_MAX)) ? fy + $urandom_range(1) : fy;
            tm = $urandom_range(1, 12);
            td = $urandom_range(1, board.month_days(ty, tm));
        end else if (pick < 70) begin
            pick_date(ty, tm, td);
        end else if (pick < 75) begin
            ty = fy;
            tm = fm;
            td = fd;
        end else if (pick < 85) begin
            fy = $urandom_range(0, 2**YEAR_W - 1);
            fm = $urandom_range(0, 2**MONTH_W - 1);
            fd = $urandom_range(0, 2**DAY_W - 1);
            ty = $urandom_range(0, 2**YEAR_W - 1);
            tm = $urandom_range(0, 2**MONTH_W - 1);
            td = $urandom_range(0, 2**DAY_W - 1);
        end else begin
            pick_date(ty, tm, td);
            if ($urandom_range(1))
                spoil_date(fy, fm, fd);
            else
                spoil_date(ty, tm, td);
        end
        send_request(fy, fm, fd, ty, tm, td);
    endtask

    initial begin
        logic [MASK_W-1:0] phase_mask[6];

        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_weekend_mask = '0;
        s_valid          = 1'b0;
        s_from_year      = '0;
        s_from_month     = '0;
        s_from_day       = '0;
        s_to_year        = '0;
        s_to_month       = '0;
        s_to_day         = '0;
        m_ready          = 1'b0;
        long_hold_armed  = 1'b0;
        board            = new();
        send_idle_pct    = 28;
        recv_idle_pct    = 88;

        phase_mask[0] = 7'h00;
        phase_mask[1] = 7'h7f;
        phase_mask[2] = MASK_W'($urandom_range(127));
        phase_mask[3] = 7'h41;
        phase_mask[4] = MASK_W'($urandom_range(127));
        phase_mask[5] = MASK_RESET;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed dates under the reset mask
        send_request(1, 1, 1, 9999, 12, 31);
        send_request(9999, 12, 31, 1, 1, 1);
        send_request(2024, 5, 17, 2024, 5, 17);
        send_request(2024, 2, 28, 2024, 3, 1);
        send_request(2000, 2, 29, 2000, 3, 7);
        send_request(1900, 2, 29, 1900, 3, 1);
        send_request(2023, 2, 29, 2023, 3, 1);
        send_request(2024, 4, 31, 2024, 5, 1);
        send_request(2024, 1, 0, 2024, 1, 5);
        send_request(2024, 0, 1, 2024, 1, 5);
        send_request(2024, 13, 1, 2024, 1, 5);
        send_request(0, 1, 1, 1, 1, 1);
        send_request(9999, 1, 1, 10000, 1, 1);
        send_request(16383, 15, 31, 16383, 15, 31);
        send_request(0, 0, 0, 0, 0, 0);
        send_request(2024, 1, 31, 2024, 12, 31);
        send_request(2024, 6, 1, 2024, 6, 31);
        for (int d = 2; d <= 7; d++)
            send_request(2024, 6, 1, 2024, 6, d);
        send_request(1, 1, 1, 1, 1, 8);

        for (int phase = 0; phase < 6; phase++) begin
            s_valid <= 1'b0;
            while (board.pending() != 0)
                @(posedge aclk);
            write_weekend_mask(phase_mask[phase]);
            if (phase < 2) begin
                send_idle_pct = 28;
                recv_idle_pct = 88;
            end else if (phase < 4) begin
                send_idle_pct = 88;
                recv_idle_pct = 28;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 4)
                long_hold_armed = 1'b1;
            repeat (PHASE_ITEMS) send_random_request();
        end

        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        // catch any stray word after the last one
        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
